FILE: design/tfc_pkg.sv
// Package for the tensor Fletcher-32 checksum block.
// Holds widths, the fold interval, register indexes and the 16-bit fold function.
// Used by the top level and by its port checker; depends on nothing else.
`default_nettype none

package tfc_pkg;

	// Words added between two folds of the running sums.
	localparam int unsigned FOLD_INTERVAL = 359;
	localparam int unsigned WORDS_W = (FOLD_INTERVAL > 1) ? $clog2(FOLD_INTERVAL) : 1;

	// Field and register widths.
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned CSUM_W    = 32;
	localparam int unsigned CFG_IDX_W = 8;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH   = 8'd0,
		REG_ROW     = 8'd1,
		REG_COLUMN  = 8'd2,
		REG_CHANNEL = 8'd3
	} cfg_reg_t;

	// Adds the upper half of a sum into its lower half.
	function automatic logic [SUM_W-1:0] fold(input logic [SUM_W-1:0] s);
		logic [WORD_W:0] f;
		f = {1'b0, s[WORD_W-1:0]} + {1'b0, s[SUM_W-1:WORD_W]};
		return {{(SUM_W-WORD_W-1){1'b0}}, f};
	endfunction

endpackage

`default_nettype wire

FILE: design/tensor_fletcher32_checksum.sv
// Top level of the tensor Fletcher-32 checksum block.
// Pairs tensor bytes into words, keeps the running sums and emits the checksum.
// Depends on tfc_pkg.
`default_nettype none

// Usage:
// Bytes of a tensor arrive on the s_ stream in batch, row, column, depth order,
// one per transfer. Bytes of one depth run are paired big-endian into words;
// an odd last byte of a run forms a word with a zero low byte. The shape is
// set through the cfg_ write channel (index 0 batches, 1 rows, 2 columns,
// 3 channels; a count of zero acts as one, other indexes are ignored) while
// the block is idle. After the last byte of the tensor one 32-bit checksum
// leaves on the m_ stream, sum2 in the upper half and sum1 in the lower half,
// and the walk and sums return to their starting values for the next tensor.
// Throughput is one byte per clock while no finished checksum is held up: the running
// sums take one add, a dependent add and an optional fold in the update of each byte.
// From the last byte to m_tvalid the checksum passes the input register, then
// the sum update into the fold stage, then the final folds into the output register.
// Reset clears the walk and all valid flags, sets the sums to 16'hffff and sets
// every count to one; there is no clearing pass. When the receiver stalls the result
// holds, and bytes keep flowing while one more finished checksum waits in the
// fold stage; the last byte of a third tensor then holds in the input register
// and s_tready drops until the output register drains.
module tensor_fletcher32_checksum (
	input  wire                             clk,
	input  wire                             arst_n,
	// Tensor byte stream.
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [tfc_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	// Checksum stream.
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [tfc_pkg::CSUM_W-1:0]      m_tdata,   // [31:0] checksum
	// Configuration write channel.
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [tfc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [tfc_pkg::CNT_W-1:0]       cfg_data
);

	localparam int unsigned CNT_W   = tfc_pkg::CNT_W;
	localparam int unsigned SUM_W   = tfc_pkg::SUM_W;
	localparam int unsigned WORD_W  = tfc_pkg::WORD_W;
	localparam int unsigned BYTE_W  = tfc_pkg::BYTE_W;
	localparam int unsigned WORDS_W = tfc_pkg::WORDS_W;

	// A count of zero behaves as one.
	function automatic logic [CNT_W-1:0] eff(input logic [CNT_W-1:0] c);
		return (c == '0) ? CNT_W'(1) : c;
	endfunction

	// Configuration registers.
	logic [CNT_W-1:0] batch_count_q, row_count_q, column_count_q, channel_count_q;

	// Walk and sum state.
	logic [SUM_W-1:0]   low_sum_q, high_sum_q;
	logic [WORDS_W-1:0] words_q;
	logic [BYTE_W-1:0]  held_byte_q;
	logic               byte_held_q;
	logic [CNT_W-1:0]   depth_pos_q, column_pos_q, row_pos_q, batch_pos_q;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// Finished sums waiting for the final folds.
	logic             valid_s2;
	logic             partial_s2;
	logic [SUM_W-1:0] low_s2, high_s2;

	// Output register.
	logic              m_tvalid_q;
	logic [tfc_pkg::CSUM_W-1:0] m_tdata_q;

	// Update logic signals.
	logic               last_in_run, add_en, done, block_full;
	logic [WORD_W-1:0]  word;
	logic [CNT_W-1:0]   column_inc, row_inc, batch_inc, depth_inc;
	logic               col_wrap, row_wrap, batch_wrap;
	logic [SUM_W-1:0]   low_add, high_add, low_new, high_new;
	logic [WORDS_W:0]   words_inc;
	logic [WORDS_W-1:0] words_new;
	logic               out_free, s2_free, s1_fire;
	logic [SUM_W-1:0]   low_f1, high_f1, low_f2, high_f2;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Flow control: the output register, the fold stage and the input register.
	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		s2_free  = !valid_s2 || out_free;
		s1_fire  = valid_s1 && (!done || s2_free);
		s_tready = !valid_s1 || s1_fire;
	end

	// Position walk: does this byte end a run, a column, a row, the tensor.
	always_comb begin
		last_in_run = ({1'b0, depth_pos_q} + (CNT_W+1)'(1)) >= {1'b0, eff(channel_count_q)};
		depth_inc   = depth_pos_q + CNT_W'(1);
		column_inc  = column_pos_q + CNT_W'(1);
		row_inc     = row_pos_q + CNT_W'(1);
		batch_inc   = batch_pos_q + CNT_W'(1);
		col_wrap    = column_inc >= eff(column_count_q);
		row_wrap    = row_inc >= eff(row_count_q);
		batch_wrap  = batch_inc >= eff(batch_count_q);
		done        = last_in_run && col_wrap && row_wrap && batch_wrap;
	end

	// Word formation and the running sums with the periodic fold.
	always_comb begin
		add_en     = byte_held_q || last_in_run;
		word       = byte_held_q ? {held_byte_q, byte_s1} : {byte_s1, {BYTE_W{1'b0}}};
		low_add    = low_sum_q + {{(SUM_W-WORD_W){1'b0}}, word};
		high_add   = high_sum_q + low_add;
		words_inc  = {1'b0, words_q} + (WORDS_W+1)'(1);
		block_full = words_inc >= (WORDS_W+1)'(tfc_pkg::FOLD_INTERVAL);
		low_new    = block_full ? tfc_pkg::fold(low_add) : low_add;
		high_new   = block_full ? tfc_pkg::fold(high_add) : high_add;
		words_new  = block_full ? '0 : words_inc[WORDS_W-1:0];
	end

	// Final folds of a finished tensor: the partial block, then once more.
	always_comb begin
		low_f1  = partial_s2 ? tfc_pkg::fold(low_s2) : low_s2;
		high_f1 = partial_s2 ? tfc_pkg::fold(high_s2) : high_s2;
		low_f2  = tfc_pkg::fold(low_f1);
		high_f2 = tfc_pkg::fold(high_f1);
	end

	// Control and walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_count_q   <= CNT_W'(1);
			row_count_q     <= CNT_W'(1);
			column_count_q  <= CNT_W'(1);
			channel_count_q <= CNT_W'(1);
			low_sum_q       <= SUM_W'(16'hffff);
			high_sum_q      <= SUM_W'(16'hffff);
			words_q         <= '0;
			held_byte_q     <= '0;
			byte_held_q     <= 1'b0;
			depth_pos_q     <= '0;
			column_pos_q    <= '0;
			row_pos_q       <= '0;
			batch_pos_q     <= '0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			m_tvalid_q      <= 1'b0;
		end else begin
			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tfc_pkg::REG_BATCH:   batch_count_q   <= cfg_data;
					tfc_pkg::REG_ROW:     row_count_q     <= cfg_data;
					tfc_pkg::REG_COLUMN:  column_count_q  <= cfg_data;
					tfc_pkg::REG_CHANNEL: channel_count_q <= cfg_data;
					default: ;
				endcase
			end

			// Input register.
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end

			// Sum and walk update for the byte in the input register.
			if (s1_fire) begin
				if (done) begin
					low_sum_q    <= SUM_W'(16'hffff);
					high_sum_q   <= SUM_W'(16'hffff);
					words_q      <= '0;
					held_byte_q  <= '0;
					byte_held_q  <= 1'b0;
					depth_pos_q  <= '0;
					column_pos_q <= '0;
					row_pos_q    <= '0;
					batch_pos_q  <= '0;
				end else begin
					if (add_en) begin
						low_sum_q  <= low_new;
						high_sum_q <= high_new;
						words_q    <= words_new;
					end
					if (byte_held_q) begin
						byte_held_q <= 1'b0;
						held_byte_q <= '0;
					end else if (!last_in_run) begin
						byte_held_q <= 1'b1;
						held_byte_q <= byte_s1;
					end
					if (last_in_run) begin
						depth_pos_q  <= '0;
						column_pos_q <= col_wrap ? '0 : column_inc;
						if (col_wrap) begin
							row_pos_q <= row_wrap ? '0 : row_inc;
							if (row_wrap) begin
								batch_pos_q <= batch_wrap ? '0 : batch_inc;
							end
						end
					end else begin
						depth_pos_q <= depth_inc;
					end
				end
			end

			// Fold stage occupancy.
			if (s1_fire && done) begin
				valid_s2 <= 1'b1;
			end else if (valid_s2 && out_free) begin
				valid_s2 <= 1'b0;
			end

			// Output register occupancy.
			if (out_free) begin
				m_tvalid_q <= valid_s2;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (s1_fire && done) begin
			low_s2     <= low_new;
			high_s2    <= high_new;
			partial_s2 <= add_en ? (words_new != '0) : (words_q != '0);
		end
		if (out_free && valid_s2) begin
			m_tdata_q <= {high_f2[WORD_W-1:0], low_f2[WORD_W-1:0]};
		end
	end

endmodule

`default_nettype wire

FILE: design/tfc_checker.sv
// Port checker for the tensor Fletcher-32 checksum block, bound to the top level.
// Watches only the top level's ports; depends on tfc_pkg for the data width.
`default_nettype none

module tfc_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_tvalid,
	input wire                         s_tready,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [tfc_pkg::CSUM_W-1:0]   m_tdata
);

	// A stalled checksum keeps its value until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("checksum changed or dropped while stalled");

	// With the output register empty nothing downstream can hold the input back.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while no checksum was waiting");

	// Reset leaves no checksum on the output.
	a_reset_clears: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("checksum valid during reset");

endmodule

bind tensor_fletcher32_checksum tfc_checker u_tfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
